@@ rtl/kmpsm_pkg.sv @@
package kmpsm_pkg;

    localparam int MAX_PATTERN_DEF = 256;
    localparam int GROUP_SIZE      = 16;
    localparam int DATA_W          = 8;
    localparam int POS_W           = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2
    } cmd_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic              clear;
        logic              load;
        logic              scan;
        logic [DATA_W-1:0] data;
    } cell_ctl_t;

endpackage

@@ rtl/kmp_stream_matcher_unit.sv @@
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  command, data_byte
// out      output     out_valid/ out_stall match_position, match_count
//
// one item per cycle unless stalled; a hit is registered in s1, s2 and the output stage
// the row of cells updates its prefix-match bits in the cycle the byte is taken,
// the match flags then pass through a two-level registered or-tree
// reset empties the pattern and clears position, count and the pipeline
// a hit reaching the last stage behind a stalled result holds the pipeline and the input
module kmp_stream_matcher_unit
    import kmpsm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [DATA_W-1:0] data_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [POS_W-1:0]  match_position,
    output logic [POS_W-1:0]  match_count
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int NGRP  = (MAX_PATTERN + GROUP_SIZE - 1) / GROUP_SIZE;

    logic                   go;
    logic                   accept;
    cmd_t                   cmd;
    cell_ctl_t              ctl;
    logic [MAX_PATTERN-1:0] hit;

    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;

    logic                   s1_valid_reg;
    logic                   s1_clear_reg;
    logic [MAX_PATTERN-1:0] s1_hit_reg;
    logic [POS_W-1:0]       s1_pos_reg;
    logic [LEN_W-1:0]       s1_len_reg;
    logic [NGRP*GROUP_SIZE-1:0] hit_pad;
    logic [NGRP-1:0]        grp;

    logic                   s2_valid_reg;
    logic                   s2_clear_reg;
    logic [NGRP-1:0]        s2_grp_reg;
    logic [POS_W-1:0]       s2_mpos_reg;
    logic                   s2_hit;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [POS_W-1:0]       match_position_reg;
    logic [POS_W-1:0]       match_count_reg;
    logic [POS_W-1:0]       count_reg;
    logic [POS_W-1:0]       count_next;

    assign cmd    = cmd_t'(command);
    assign s2_hit = |s2_grp_reg;
    assign go     = !(s2_valid_reg && s2_hit && out_valid_reg && out_stall);
    assign accept = in_valid && go;

    assign in_stall = !go;

    always_comb
    begin
        ctl.clear = accept && (cmd == CMD_CLEAR);
        ctl.load  = accept && (cmd == CMD_APPEND);
        ctl.scan  = accept && (cmd == CMD_TEXT);
        ctl.data  = data_byte;
    end

    kmpsm_row #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .hit   (hit)
    );

    always_comb
    begin
        len_next = len_reg;
        pos_next = pos_reg;
        if (ctl.clear)
        begin
            len_next = '0;
            pos_next = '0;
        end
        else if (ctl.load)
        begin
            if (len_reg != LEN_W'(MAX_PATTERN))
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
        else if (ctl.scan)
        begin
            if (pos_reg != {POS_W{1'b1}})
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        hit_pad                  = '0;
        hit_pad[MAX_PATTERN-1:0] = s1_hit_reg;
    end

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        assign grp[g] = |hit_pad[g*GROUP_SIZE +: GROUP_SIZE];
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (go && s2_valid_reg)
        begin
            if (s2_clear_reg)
            begin
                count_next = '0;
            end
            else if (s2_hit)
            begin
                if (count_reg != {POS_W{1'b1}})
                begin
                    count_next = count_reg + POS_W'(1);
                end
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_clear_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_clear_reg  <= 1'b0;
            s2_grp_reg    <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (go)
            begin
                s1_valid_reg <= accept;
                s1_clear_reg <= ctl.clear;
                s2_valid_reg <= s1_valid_reg;
                s2_clear_reg <= s1_clear_reg;
                s2_grp_reg   <= s1_valid_reg ? grp : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_hit_reg  <= hit;
            s1_pos_reg  <= pos_next;
            s1_len_reg  <= len_reg;
            s2_mpos_reg <= s1_pos_reg - POS_W'(s1_len_reg) + POS_W'(1);
            if (s2_valid_reg && !s2_clear_reg && s2_hit)
            begin
                match_position_reg <= s2_mpos_reg;
                match_count_reg    <= count_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign match_position = match_position_reg;
    assign match_count    = match_count_reg;

endmodule

@@ rtl/kmpsm_cell.sv @@
module kmpsm_cell
    import kmpsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      prev_bit,
    input  logic      prev_valid,
    input  logic      next_valid,
    output logic      bit_q,
    output logic      valid_q,
    output logic      hit
);

    logic [DATA_W-1:0] data_reg;
    logic              valid_reg;
    logic              valid_next;
    logic              bit_reg;
    logic              bit_next;
    logic              match;
    logic              last;

    // this cell extends a prefix match ending one text byte earlier
    assign match = valid_reg & prev_bit & (data_reg == ctl.data);
    assign last  = valid_reg & ~next_valid;
    assign hit   = ctl.scan & match & last;

    always_comb
    begin
        valid_next = valid_reg;
        bit_next   = bit_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
            bit_next   = 1'b0;
        end
        else if (ctl.load)
        begin
            if (prev_valid && !valid_reg)
            begin
                valid_next = 1'b1;
            end
        end
        else if (ctl.scan)
        begin
            // a full match falls back to its borders, held by the shorter cells
            bit_next = match & ~last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            bit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && prev_valid && !valid_reg)
        begin
            data_reg <= ctl.data;
        end
    end

    assign bit_q   = bit_reg;
    assign valid_q = valid_reg;

endmodule

@@ rtl/kmpsm_row.sv @@
module kmpsm_row
    import kmpsm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctl_t              ctl,
    output logic [MAX_PATTERN-1:0] hit
);

    logic [MAX_PATTERN-1:0] bits;
    logic [MAX_PATTERN-1:0] valids;
    logic [MAX_PATTERN:0]   bit_chain;
    logic [MAX_PATTERN+1:0] valid_chain;

    // cell 0 always has a matched empty prefix before it, nothing follows the last cell
    assign bit_chain   = {bits, 1'b1};
    assign valid_chain = {1'b0, valids, 1'b1};

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        kmpsm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_bit   (bit_chain[j]),
            .prev_valid (valid_chain[j]),
            .next_valid (valid_chain[j+2]),
            .bit_q      (bits[j]),
            .valid_q    (valids[j]),
            .hit        (hit[j])
        );
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

typedef struct {
    logic [31:0] position;
    logic [31:0] count;
} match_t;

class kmp_match_board;
    logic [7:0]  pat_bytes [kmpsm_pkg::MAX_PATTERN_DEF];
    logic [8:0]  borders [kmpsm_pkg::MAX_PATTERN_DEF + 1];
    int unsigned pat_len;
    int unsigned matched;
    logic [31:0] text_pos;
    logic [31:0] found;
    match_t      pending[$];
    int          errors;
    int          checked;
    int          n_clear;
    int          n_append;
    int          n_text;
    int          longest;

    // walk border links until the next pattern byte equals b, then extend
    function int unsigned extend(int unsigned k, logic [7:0] b);
        int unsigned nk;
        while (k > 0 && k < kmpsm_pkg::MAX_PATTERN_DEF && pat_bytes[k] != b)
        begin
            nk = borders[k];
            k = (nk < k) ? nk : 0;
        end
        if (k < kmpsm_pkg::MAX_PATTERN_DEF && pat_bytes[k] == b)
            k++;
        return k;
    endfunction

    function void take_item(logic [1:0] cmd, logic [7:0] b);
        int unsigned q;
        match_t m;
        if (cmd == kmpsm_pkg::CMD_CLEAR)
        begin
            n_clear++;
            pat_len = 0;
            matched = 0;
            text_pos = '0;
            found = '0;
        end
        else if (cmd == kmpsm_pkg::CMD_APPEND)
        begin
            n_append++;
            if (pat_len < kmpsm_pkg::MAX_PATTERN_DEF)
            begin
                pat_bytes[pat_len] = b;
                if (pat_len == 0)
                    borders[1] = '0;
                else
                    borders[pat_len + 1] = 9'(extend(borders[pat_len], b));
                pat_len++;
                if (pat_len > longest)
                    longest = pat_len;
            end
        end
        else if (cmd == kmpsm_pkg::CMD_TEXT)
        begin
            n_text++;
            if (text_pos != '1)
                text_pos++;
            if (pat_len != 0)
            begin
                q = matched;
                if (q >= pat_len)
                    q = borders[pat_len];
                q = extend(q, b);
                if (q >= pat_len)
                begin
                    if (found != '1)
                        found++;
                    m.position = text_pos - 32'(pat_len) + 32'd1;
                    m.count = found;
                    pending = {pending, m};
                    matched = borders[pat_len];
                end
                else
                    matched = q;
            end
        end
    endfunction

    function void report(string what, match_t exp, logic [31:0] pos, logic [31:0] cnt);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected position %0d count %0d, got position %0d count %0d",
                     $time, what, exp.position, exp.count, pos, cnt);
    endfunction

    function void check_match(logic [31:0] pos, logic [31:0] cnt);
        match_t exp;
        if (pending.size() == 0)
        begin
            exp.position = '0;
            exp.count = '0;
            report("unexpected match", exp, pos, cnt);
        end
        else
        begin
            exp = pending.pop_front();
            checked++;
            if (exp.position != pos)
                report("wrong match_position", exp, pos, cnt);
            else if (exp.count != cnt)
                report("wrong match_count", exp, pos, cnt);
        end
    endfunction
endclass

module testbench;
    import kmpsm_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_CLEAR;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] match_position;
    logic [31:0] match_count;

    int             send_idle = 0;
    int             recv_idle = 0;
    int             n_items = 0;
    int             cycles = 0;
    bit             hold_req = 1'b0;
    logic           drain_hold = 1'b0;
    kmp_match_board board;

    kmp_stream_matcher_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_position (match_position),
        .match_count    (match_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= drain_hold || ($urandom_range(99) < recv_idle);
    end

    // long output hold while the sender keeps offering
    initial
    begin
        @(posedge hold_req);
        @(posedge clk);
        drain_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        drain_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.take_item(command, data_byte);
            if (out_valid && !out_stall)
                board.check_match(match_position, match_count);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (cmd != CMD_UNUSED)
            n_items++;
    endtask

    // mostly clear, short pattern over a tiny alphabet, text seeded with copies
    task automatic run_sequence();
        logic [7:0] alpha [3];
        logic [7:0] pat_q [$];
        logic [7:0] b;
        int         n_alpha;
        int         plen;
        int         tlen;
        int         i;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                send_item(2'($urandom_range(3)), 8'($urandom));
            return;
        end
        n_alpha = $urandom_range(2, 3);
        for (i = 0; i < 3; i++)
            alpha[i] = 8'($urandom);
        if ($urandom_range(9) != 0)
            send_item(CMD_CLEAR, 8'($urandom));
        plen = ($urandom_range(5) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
        for (i = 0; i < plen; i++)
        begin
            b = alpha[$urandom_range(n_alpha - 1)];
            pat_q = {pat_q, b};
            send_item(CMD_APPEND, b);
        end
        tlen = $urandom_range(10, 40);
        i = 0;
        while (i < tlen)
        begin
            if ($urandom_range(99) < 30)
            begin
                foreach (pat_q[k])
                    send_item(CMD_TEXT, pat_q[k]);
                i += pat_q.size();
            end
            else if ($urandom_range(99) < 5)
            begin
                // grow the pattern in the middle of the text
                b = alpha[$urandom_range(n_alpha - 1)];
                pat_q = {pat_q, b};
                send_item(CMD_APPEND, b);
            end
            else if ($urandom_range(99) < 4)
            begin
                send_item(CMD_TEXT, 8'($urandom));
                i++;
            end
            else
            begin
                send_item(CMD_TEXT, alpha[$urandom_range(n_alpha - 1)]);
                i++;
            end
        end
    endtask

    initial
    begin
        board = new();
        send_idle = 33;
        recv_idle = 74;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern and the unused command
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_UNUSED, 8'hA5);
        // pattern with a border, overlapping hits
        send_item(CMD_APPEND, 8'h00);
        send_item(CMD_APPEND, 8'hFF);
        send_item(CMD_APPEND, 8'h00);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_TEXT, 8'h00);
        // pattern grown mid-text keeps the partial match
        send_item(CMD_APPEND, 8'hFF);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_UNUSED, 8'h5A);
        send_item(CMD_CLEAR, 8'hFF);
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_APPEND, 8'h80);
        send_item(CMD_TEXT, 8'h80);
        send_item(CMD_TEXT, 8'h7F);
        send_item(CMD_TEXT, 8'h80);

        // one-byte pattern gives a hit per text byte while the output is held
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_APPEND, 8'h33);
        hold_req = 1'b1;
        repeat (60) send_item(CMD_TEXT, 8'h33);

        while (n_items < 150) run_sequence();
        send_idle = 74;
        recv_idle = 33;
        while (n_items < 300) run_sequence();
        send_idle = 0;
        recv_idle = 0;
        while (n_items < 450) run_sequence();
        in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);

        $display("run covered %0d clears, %0d pattern and %0d text transfers, longest pattern %0d",
                 board.n_clear, board.n_append, board.n_text, board.longest);
        $display("%0d matches checked, %0d-cycle output hold, %0d mismatches",
                 board.checked, HOLD_CYCLES, board.errors);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ files.f @@
rtl/kmpsm_pkg.sv
rtl/kmpsm_cell.sv
rtl/kmpsm_row.sv
rtl/kmp_stream_matcher_unit.sv
bench/testbench.sv
